// ===== src/ria_pkg.sv =====
// Shared types, operation codes and helper functions for the interval ALU.
package ria_pkg;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_AND = 5'd2, OP_OR = 5'd3, OP_XOR = 5'd4,
        OP_NOT = 5'd5, OP_MUL = 5'd6, OP_LSH = 5'd7, OP_RSH = 5'd8, OP_URSH = 5'd9,
        OP_LSHR = 5'd10, OP_RSHR = 5'd11, OP_URSHR = 5'd12, OP_ABS = 5'd13,
        OP_MIN = 5'd14, OP_MAX = 5'd15, OP_FLOOR = 5'd16, OP_CEIL = 5'd17,
        OP_SIGN = 5'd18, OP_ISECT = 5'd19, OP_UNION = 5'd20
    } op_t;

    localparam logic [10:0] EXP_FIN_MAX = 11'd1023;
    localparam logic [10:0] EXP_INF = 11'd1024;
    localparam logic [10:0] EXP_NAN = 11'd1025;
    localparam logic signed [31:0] I32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] I32_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               hl;
        logic               hu;
        logic               fr;
        logic               nz;
        logic [10:0]        ex;
    } rng_t;

    typedef struct packed {
        rng_t r;
        logic empty;
    } res_t;

    function automatic logic [5:0] clz32(input logic [31:0] x);
        logic [5:0] n;
        logic       done;
        n = 6'd32;
        done = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!done && x[i]) begin
                n = 6'(31 - i);
                done = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] lowmask(input logic [5:0] n);
        return n[5] ? 32'd0 : (32'hffffffff >> n[4:0]);
    endfunction

    function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic rng_t unknown_rng();
        rng_t r;
        r.lo = I32_MIN;
        r.hi = I32_MAX;
        r.hl = 1'b0;
        r.hu = 1'b0;
        r.fr = 1'b1;
        r.nz = 1'b1;
        r.ex = EXP_NAN;
        return r;
    endfunction

    function automatic rng_t i32r(input logic signed [31:0] lo,
                                  input logic signed [31:0] hi);
        rng_t r;
        r.lo = lo;
        r.hi = hi;
        r.hl = 1'b1;
        r.hu = 1'b1;
        r.fr = 1'b0;
        r.nz = 1'b0;
        r.ex = 11'd31;
        return r;
    endfunction

    // Clamps 65-bit signed bounds into int32 and sets the valid flags.
    function automatic rng_t r4(input logic signed [64:0] lo, input logic signed [64:0] hi,
                                input logic fr, input logic nz, input logic [10:0] ex);
        rng_t r;
        if (lo > 65'sd2147483647) begin
            r.lo = I32_MAX;
            r.hl = 1'b1;
        end else if (lo < -65'sd2147483648) begin
            r.lo = I32_MIN;
            r.hl = 1'b0;
        end else begin
            r.lo = lo[31:0];
            r.hl = 1'b1;
        end
        if (hi > 65'sd2147483647) begin
            r.hi = I32_MAX;
            r.hu = 1'b0;
        end else if (hi < -65'sd2147483648) begin
            r.hi = I32_MIN;
            r.hu = 1'b1;
        end else begin
            r.hi = hi[31:0];
            r.hu = 1'b1;
        end
        r.fr = fr;
        r.nz = nz;
        r.ex = ex;
        return r;
    endfunction

endpackage

// ===== src/ria_decode.sv =====
// First stage: loads the operands and computes everything except the product and the rounding exponent.
module ria_decode
    import ria_pkg::*;
(
    input  logic [4:0]         kind,
    input  logic signed [31:0] left_lower,
    input  logic signed [31:0] left_upper,
    input  logic [3:0]         left_flags,
    input  logic [10:0]        left_exponent,
    input  logic signed [31:0] right_lower,
    input  logic signed [31:0] right_upper,
    input  logic [3:0]         right_flags,
    input  logic [10:0]        right_exponent,
    input  logic [4:0]         shift_count,
    output res_t               res,
    output rng_t               a_rng,
    output rng_t               b_rng,
    output logic [10:0]        mul_ex,
    output logic               mul_fr,
    output logic               mul_nz,
    output logic               is_mul,
    output logic               is_round
);

    rng_t a;
    rng_t b;

    always_comb
    begin
        a.lo = left_lower;
        a.hi = left_upper;
        {a.nz, a.fr, a.hu, a.hl} = left_flags;
        a.ex = (left_exponent > EXP_NAN) ? EXP_NAN : left_exponent;
        b.lo = right_lower;
        b.hi = right_upper;
        {b.nz, b.fr, b.hu, b.hl} = right_flags;
        b.ex = (right_exponent > EXP_NAN) ? EXP_NAN : right_exponent;
    end

    assign a_rng = a;
    assign b_rng = b;
    assign is_mul = (kind == OP_MUL);
    assign is_round = (kind == OP_FLOOR) || (kind == OP_CEIL);

    // Multiply flags and exponent class.
    always_comb
    begin
        logic sa;
        logic sb;
        logic [11:0] es;
        sa = !a.hl || a.lo < 0 || a.nz;
        sb = !b.hl || b.lo < 0 || b.nz;
        mul_nz = (sa && b.hi >= 0) || (sb && a.hi >= 0);
        mul_fr = a.fr || b.fr;
        es = 12'(a.ex) + 12'(b.ex) + 12'd1;
        if (a.ex < EXP_INF && b.ex < EXP_INF)
            mul_ex = (es > 12'(EXP_FIN_MAX)) ? EXP_INF : es[10:0];
        else if (a.ex != EXP_NAN && b.ex != EXP_NAN
                 && !(a.lo <= 0 && a.hi >= 0 && b.ex >= EXP_INF)
                 && !(b.lo <= 0 && b.hi >= 0 && a.ex >= EXP_INF))
            mul_ex = EXP_INF;
        else
            mul_ex = EXP_NAN;
    end

    always_comb
    begin
        logic [10:0] se;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] al;
        logic signed [31:0] ah;
        logic signed [31:0] bl;
        logic signed [31:0] bh;
        logic signed [31:0] t;
        logic signed [31:0] up;
        logic signed [31:0] dn;
        logic inv;
        logic [5:0] ca;
        logic [5:0] cb;
        logic [4:0] sl;
        logic [4:0] su;
        logic [31:0] ul;
        logic [31:0] uh;
        logic signed [32:0] diff;

        se = (a.ex > b.ex) ? a.ex : b.ex;
        if (se <= EXP_FIN_MAX)
            se = se + 11'd1;
        if (a.ex >= EXP_INF && b.ex >= EXP_INF)
            se = EXP_NAN;
        res.empty = 1'b0;
        res.r = unknown_rng();
        lo = I32_MIN;
        hi = I32_MAX;
        inv = 1'b0;
        al = a.lo;
        ah = a.hi;
        bl = b.lo;
        bh = b.hi;
        t = '0;
        up = '0;
        dn = '0;
        ca = '0;
        cb = '0;
        sl = '0;
        su = '0;
        ul = '0;
        uh = '0;
        diff = '0;
        case (kind)
            OP_ADD:
                res.r = r4(a.hl && b.hl ? 65'(a.lo) + 65'(b.lo) : -65'sd2147483649,
                           a.hu && b.hu ? 65'(a.hi) + 65'(b.hi) : 65'sd2147483648,
                           a.fr || b.fr, a.nz && b.nz, se);
            OP_SUB:
                res.r = r4(a.hl && b.hu ? 65'(a.lo) - 65'(b.hi) : -65'sd2147483649,
                           a.hu && b.hl ? 65'(a.hi) - 65'(b.lo) : 65'sd2147483648,
                           a.fr || b.fr, a.nz && (b.lo <= 0 && b.hi >= 0), se);
            OP_AND:
                if (a.lo < 0 && b.lo < 0)
                    res.r = i32r(I32_MIN, smax(a.hi, b.hi));
                else begin
                    hi = smin(a.hi, b.hi);
                    if (a.lo < 0)
                        hi = b.hi;
                    if (b.lo < 0)
                        hi = a.hi;
                    res.r = i32r('0, hi);
                end
            OP_OR:
                if (a.lo == a.hi && a.lo == 0)
                    res.r = b;
                else if (a.lo == a.hi && a.lo == -1)
                    res.r = a;
                else if (b.lo == b.hi && b.lo == 0)
                    res.r = a;
                else if (b.lo == b.hi && b.lo == -1)
                    res.r = b;
                else begin
                    if (a.lo >= 0 && b.lo >= 0) begin
                        ca = clz32(a.hi);
                        cb = clz32(b.hi);
                        lo = smax(a.lo, b.lo);
                        hi = lowmask((ca < cb) ? ca : cb);
                    end else begin
                        if (a.hi < 0) begin
                            lo = smax(lo, ~lowmask(clz32(~a.lo)));
                            hi = -32'sd1;
                        end
                        if (b.hi < 0) begin
                            lo = smax(lo, ~lowmask(clz32(~b.lo)));
                            hi = -32'sd1;
                        end
                    end
                    res.r = i32r(lo, hi);
                end
            OP_XOR:
            begin
                if (ah < 0) begin
                    t = ~al;
                    al = ~ah;
                    ah = t;
                    inv = !inv;
                end
                if (bh < 0) begin
                    t = ~bl;
                    bl = ~bh;
                    bh = t;
                    inv = !inv;
                end
                if (al == 0 && ah == 0) begin
                    lo = bl;
                    hi = bh;
                end else if (bl == 0 && bh == 0) begin
                    lo = al;
                    hi = ah;
                end else if (al >= 0 && bl >= 0) begin
                    up = bh | lowmask(clz32(ah));
                    dn = ah | lowmask(clz32(bh));
                    lo = '0;
                    hi = smin(up, dn);
                end
                if (inv) begin
                    t = ~lo;
                    lo = ~hi;
                    hi = t;
                end
                res.r = i32r(lo, hi);
            end
            OP_NOT:
                res.r = i32r(~a.hi, ~a.lo);
            OP_LSH:
            begin
                // A bound fits when its top shift_count+1 bits are all zero.
                ul = $unsigned(a.lo) << shift_count;
                ul = (ul << 1) >> shift_count;
                ul = ul >> 1;
                uh = $unsigned(a.hi) << shift_count;
                uh = (uh << 1) >> shift_count;
                uh = uh >> 1;
                if (ul == $unsigned(a.lo) && uh == $unsigned(a.hi))
                    res.r = i32r(a.lo <<< shift_count, a.hi <<< shift_count);
                else
                    res.r = i32r(I32_MIN, I32_MAX);
            end
            OP_RSH:
                res.r = i32r(a.lo >>> shift_count, a.hi >>> shift_count);
            OP_URSH:
            begin
                if (a.lo > 0 || a.hi < 0) begin
                    ul = 32'(a.lo) >> shift_count;
                    uh = 32'(a.hi) >> shift_count;
                end else begin
                    ul = '0;
                    uh = 32'hffffffff >> shift_count;
                end
                res.r = r4(65'({1'b0, ul}), 65'({1'b0, uh}), 1'b0, 1'b0, 11'd31);
            end
            OP_LSHR:
                res.r = i32r(I32_MIN, I32_MAX);
            OP_RSHR:
            begin
                diff = 33'(b.hi) - 33'(b.lo);
                if (diff >= 33'sd31) begin
                    sl = 5'd0;
                    su = 5'd31;
                end else begin
                    sl = b.lo[4:0];
                    su = b.hi[4:0];
                    if (sl > su) begin
                        sl = 5'd0;
                        su = 5'd31;
                    end
                end
                lo = (a.lo < 0) ? (a.lo >>> sl) : (a.lo >>> su);
                hi = (a.hi >= 0) ? (a.hi >>> sl) : (a.hi >>> su);
                res.r = i32r(lo, hi);
            end
            OP_URSHR:
            begin
                uh = (a.lo > 0) ? 32'(a.hi) : 32'hffffffff;
                res.r = r4(65'sd0, 65'({1'b0, uh}), 1'b0, 1'b0, 11'd31);
            end
            OP_ABS:
            begin
                res.r.lo = smax(smax('0, a.lo), (a.hi == I32_MIN) ? I32_MAX : -a.hi);
                res.r.hi = smax(smax('0, a.hi), (a.lo == I32_MIN) ? I32_MAX : -a.lo);
                res.r.hl = 1'b1;
                res.r.hu = a.hl && a.hu && a.lo != I32_MIN;
                res.r.fr = a.fr;
                res.r.nz = 1'b0;
                res.r.ex = a.ex;
            end
            OP_MIN, OP_MAX:
            begin
                res.r.lo = (kind == OP_MIN) ? smin(a.lo, b.lo) : smax(a.lo, b.lo);
                res.r.hi = (kind == OP_MIN) ? smin(a.hi, b.hi) : smax(a.hi, b.hi);
                res.r.hl = (kind == OP_MIN) ? (a.hl && b.hl) : (a.hl || b.hl);
                res.r.hu = (kind == OP_MIN) ? (a.hu || b.hu) : (a.hu && b.hu);
                res.r.fr = a.fr || b.fr;
                res.r.nz = a.nz || b.nz;
                res.r.ex = (a.ex > b.ex) ? a.ex : b.ex;
            end
            OP_FLOOR, OP_CEIL:
            begin
                // For floor the lower bound is adjusted here; the exponent is finished downstream.
                res.r = a;
                if (kind == OP_FLOOR && a.fr && a.hl) begin
                    if (a.lo == I32_MIN)
                        res.r.hl = 1'b0;
                    else
                        res.r.lo = a.lo - 32'sd1;
                end
                res.r.fr = 1'b0;
            end
            OP_SIGN:
                if (a.ex != EXP_NAN)
                    res.r = r4(65'(smax(smin(a.lo, 32'sd1), -32'sd1)),
                               65'(smax(smin(a.hi, 32'sd1), -32'sd1)),
                               1'b0, a.nz, 11'd0);
            OP_ISECT:
            begin
                lo = smax(a.lo, b.lo);
                hi = smin(a.hi, b.hi);
                if (hi < lo)
                    res.empty = (a.ex != EXP_NAN) || (b.ex != EXP_NAN);
                else begin
                    res.r.lo = lo;
                    res.r.hi = hi;
                    res.r.hl = a.hl || b.hl;
                    res.r.hu = a.hu || b.hu;
                    res.r.nz = a.nz && b.nz;
                    res.r.fr = a.fr && b.fr;
                    res.r.ex = (a.ex < b.ex) ? a.ex : b.ex;
                    if (res.r.hl && res.r.hu && res.r.ex == EXP_NAN)
                        res.r = unknown_rng();
                end
            end
            OP_UNION:
            begin
                res.r.lo = smin(a.lo, b.lo);
                res.r.hi = smax(a.hi, b.hi);
                res.r.hl = a.hl && b.hl;
                res.r.hu = a.hu && b.hu;
                res.r.fr = a.fr || b.fr;
                res.r.nz = a.nz || b.nz;
                res.r.ex = (a.ex > b.ex) ? a.ex : b.ex;
            end
            default:
                res.r = unknown_rng();
        endcase
    end

endmodule

// ===== src/ria_mul.sv =====
// Second stage: four 32x32 signed corner products of the multiply.
module ria_mul
    import ria_pkg::*;
(
    input  rng_t               a,
    input  rng_t               b,
    output logic signed [63:0] p0,
    output logic signed [63:0] p1,
    output logic signed [63:0] p2,
    output logic signed [63:0] p3
);

    assign p0 = 64'(a.lo) * 64'(b.lo);
    assign p1 = 64'(a.lo) * 64'(b.hi);
    assign p2 = 64'(a.hi) * 64'(b.lo);
    assign p3 = 64'(a.hi) * 64'(b.hi);

endmodule

// ===== src/ria_finish.sv =====
// Third stage: product min/max with clamping, and the rounding exponent.
module ria_finish
    import ria_pkg::*;
(
    input  res_t               res_in,
    input  logic               is_mul,
    input  logic               is_round,
    input  logic               bounded_ab,
    input  logic signed [63:0] p0,
    input  logic signed [63:0] p1,
    input  logic signed [63:0] p2,
    input  logic signed [63:0] p3,
    input  logic [10:0]        mul_ex,
    input  logic               mul_fr,
    input  logic               mul_nz,
    output res_t               res_out
);

    always_comb
    begin
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic [31:0] ml;
        logic [31:0] mh;
        logic [31:0] m;
        lo = p0;
        hi = p0;
        if (p1 < lo) lo = p1;
        if (p1 > hi) hi = p1;
        if (p2 < lo) lo = p2;
        if (p2 > hi) hi = p2;
        if (p3 < lo) lo = p3;
        if (p3 > hi) hi = p3;
        ml = res_in.r.lo[31] ? (32'd0 - 32'(res_in.r.lo)) : 32'(res_in.r.lo);
        mh = res_in.r.hi[31] ? (32'd0 - 32'(res_in.r.hi)) : 32'(res_in.r.hi);
        m = (ml > mh) ? ml : mh;
        res_out = res_in;
        if (is_mul) begin
            res_out.empty = 1'b0;
            if (bounded_ab)
                res_out.r = r4(65'(lo), 65'(hi), mul_fr, mul_nz, mul_ex);
            else
                res_out.r = r4(-65'sd2147483649, 65'sd2147483648, mul_fr, mul_nz, mul_ex);
        end else if (is_round) begin
            if (res_in.r.hl && res_in.r.hu)
                res_out.r.ex = 11'(6'd31 - clz32(m | 32'd1));
            else if (res_in.r.ex < EXP_FIN_MAX)
                res_out.r.ex = res_in.r.ex + 11'd1;
        end
    end

endmodule

// ===== src/int32_range_interval_alu_top.sv =====
// Top level of the 32-bit integer interval ALU.
// Usage: present an item on the input channel (valid, stall) with the
// operation code, two range descriptors and a constant shift count. The
// block answers with one result item per input item on the output channel
// (out_valid, out_stall).
// The pipeline has a decode stage that does all transfer functions except
// multiply, a stage with four 32x32 corner multipliers, and a stage that
// selects the product extremes, clamps them, and finishes the rounding
// exponent. One item may enter every cycle while stall is low. While
// out_stall is high the last stage holds and earlier stages fill bubbles;
// stall goes high only when every stage is full and the last cannot move.
// Reset clears all stage valid bits; no result is pending.
module int32_range_interval_alu_top
    import ria_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic [4:0]         kind,
    input  logic signed [31:0] left_lower,
    input  logic signed [31:0] left_upper,
    input  logic [3:0]         left_flags,
    input  logic [10:0]        left_exponent,
    input  logic signed [31:0] right_lower,
    input  logic signed [31:0] right_upper,
    input  logic [3:0]         right_flags,
    input  logic [10:0]        right_exponent,
    input  logic [4:0]         shift_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_lower,
    output logic signed [31:0] out_upper,
    output logic [3:0]         out_flags,
    output logic [10:0]        out_exponent,
    output logic               out_empty
);

    typedef struct packed {
        res_t        res;
        logic [10:0] mul_ex;
        logic        mul_fr;
        logic        mul_nz;
        logic        is_mul;
        logic        is_round;
        logic        bnd;
    } ctl_t;

    res_t d_res;
    rng_t d_a;
    rng_t d_b;
    ctl_t d_ctl;
    logic [10:0] d_mex;
    logic d_mfr;
    logic d_mnz;
    logic d_ismul;
    logic d_isround;

    logic v1_reg, v2_reg, v3_reg;
    ctl_t c1_reg, c2_reg;
    rng_t a1_reg, b1_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [63:0] p0_next, p1_next, p2_next, p3_next;
    res_t r3_reg;
    res_t r3_next;
    logic en3, en2, en1;

    ria_decode u_dec (
        .kind(kind), .left_lower(left_lower), .left_upper(left_upper),
        .left_flags(left_flags), .left_exponent(left_exponent),
        .right_lower(right_lower), .right_upper(right_upper),
        .right_flags(right_flags), .right_exponent(right_exponent),
        .shift_count(shift_count), .res(d_res), .a_rng(d_a), .b_rng(d_b),
        .mul_ex(d_mex), .mul_fr(d_mfr), .mul_nz(d_mnz),
        .is_mul(d_ismul), .is_round(d_isround)
    );

    always_comb
    begin
        d_ctl.res = d_res;
        d_ctl.mul_ex = d_mex;
        d_ctl.mul_fr = d_mfr;
        d_ctl.mul_nz = d_mnz;
        d_ctl.is_mul = d_ismul;
        d_ctl.is_round = d_isround;
        d_ctl.bnd = d_a.hl && d_a.hu && d_b.hl && d_b.hu;
    end

    ria_mul u_mul (
        .a(a1_reg), .b(b1_reg),
        .p0(p0_next), .p1(p1_next), .p2(p2_next), .p3(p3_next)
    );

    ria_finish u_fin (
        .res_in(c2_reg.res), .is_mul(c2_reg.is_mul), .is_round(c2_reg.is_round),
        .bounded_ab(c2_reg.bnd), .p0(p0_reg), .p1(p1_reg), .p2(p2_reg), .p3(p3_reg),
        .mul_ex(c2_reg.mul_ex), .mul_fr(c2_reg.mul_fr), .mul_nz(c2_reg.mul_nz),
        .res_out(r3_next)
    );

    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) begin
            c1_reg <= d_ctl;
            a1_reg <= d_a;
            b1_reg <= d_b;
        end
        if (en2) begin
            c2_reg <= c1_reg;
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
        if (en3)
            r3_reg <= r3_next;
    end

    assign out_valid = v3_reg;
    assign out_lower = r3_reg.r.lo;
    assign out_upper = r3_reg.r.hi;
    assign out_flags = {r3_reg.r.nz, r3_reg.r.fr, r3_reg.r.hu, r3_reg.r.hl};
    assign out_exponent = r3_reg.r.ex;
    assign out_empty = r3_reg.empty;

endmodule

// ===== src/ria_checker.sv =====
// Port-level checker for the interval ALU, bound to the top level.
module ria_checker
    import ria_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  out_flags,
    input logic [10:0] out_exponent,
    input logic        out_empty
);

    // A rising out_valid must be preceded by input activity.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid, 3))
        else $error("result appeared without input item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_flags) && $stable(out_exponent))
        else $error("stalled result changed");

    // Input is only held off while the output is stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_exponent <= EXP_NAN)
        else $error("exponent class out of range");

    // An empty intersection reports the unknown range.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty |-> out_flags == 4'b1100 && out_exponent == EXP_NAN)
        else $error("empty result is not the unknown range");

endmodule

bind int32_range_interval_alu_top ria_checker u_ria_checker (
    .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_flags(out_flags),
    .out_exponent(out_exponent), .out_empty(out_empty)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the interval ALU: directed table, then random items.
module tb;
    import ria_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 950;
    localparam int IDLE_LIMIT   = 1000;
    localparam int LONG_HOLD    = 300;

    typedef struct {
        logic [4:0]         kind;
        logic signed [31:0] a_lo, a_hi;
        logic [3:0]         a_flags;
        logic [10:0]        a_ex;
        logic signed [31:0] b_lo, b_hi;
        logic [3:0]         b_flags;
        logic [10:0]        b_ex;
        logic [4:0]         sc;
    } stim_t;

    typedef struct {
        logic signed [31:0] lo, hi;
        bit                 hl, hu, fr, nz;
        logic [10:0]        ex;
        bit                 empty;
    } span_t;

    typedef struct {
        stim_t s;
        bit    has_exp;
        span_t exp;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               valid = 1'b0;
    logic               stall;
    logic [4:0]         kind = '0;
    logic signed [31:0] left_lower = '0, left_upper = '0;
    logic [3:0]         left_flags = '0;
    logic [10:0]        left_exponent = '0;
    logic signed [31:0] right_lower = '0, right_upper = '0;
    logic [3:0]         right_flags = '0;
    logic [10:0]        right_exponent = '0;
    logic [4:0]         shift_count = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] out_lower, out_upper;
    logic [3:0]         out_flags;
    logic [10:0]        out_exponent;
    logic               out_empty;

    span_t     pending_spans[$];
    plan_row_t plan[$];
    int        failures = 0;
    int        results_seen = 0;
    int        idle_cycles = 0;

    int32_range_interval_alu_top uut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------- range predictor ----------------

    function automatic int lead_zeros(input logic [31:0] x);
        for (int i = 31; i >= 0; i--)
            if (x[i]) return 31 - i;
        return 32;
    endfunction

    function automatic logic [31:0] low_ones(input int n);
        return (n >= 32) ? 32'd0 : (32'hffffffff >> n);
    endfunction

    function automatic logic signed [31:0] bigger(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [31:0] smaller(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic span_t unknown_span(input bit e);
        span_t r;
        r.lo = I32_MIN; r.hi = I32_MAX;
        r.hl = 0; r.hu = 0; r.fr = 1; r.nz = 1;
        r.ex = EXP_NAN; r.empty = e;
        return r;
    endfunction

    function automatic span_t int_span(input logic signed [31:0] lo,
                                       input logic signed [31:0] hi);
        span_t r;
        r.lo = lo; r.hi = hi;
        r.hl = 1; r.hu = 1; r.fr = 0; r.nz = 0;
        r.ex = 11'd31; r.empty = 0;
        return r;
    endfunction

    function automatic span_t clamp_span(input longint lo, input longint hi, input bit fr,
                                         input bit nz, input logic [10:0] ex);
        span_t r;
        if (lo > 64'sd2147483647) begin r.lo = I32_MAX; r.hl = 1; end
        else if (lo < -64'sd2147483648) begin r.lo = I32_MIN; r.hl = 0; end
        else begin r.lo = lo[31:0]; r.hl = 1; end
        if (hi > 64'sd2147483647) begin r.hi = I32_MAX; r.hu = 0; end
        else if (hi < -64'sd2147483648) begin r.hi = I32_MIN; r.hu = 1; end
        else begin r.hi = hi[31:0]; r.hu = 1; end
        r.fr = fr; r.nz = nz; r.ex = ex; r.empty = 0;
        return r;
    endfunction

    function automatic span_t unpack_operand(input logic signed [31:0] lo,
                                             input logic signed [31:0] hi,
                                             input logic [3:0] f, input logic [10:0] e);
        span_t r;
        r.lo = lo; r.hi = hi;
        r.hl = f[0]; r.hu = f[1]; r.fr = f[2]; r.nz = f[3];
        r.ex = (e > EXP_NAN) ? EXP_NAN : e;
        r.empty = 0;
        return r;
    endfunction

    function automatic bit has_zero(input span_t r);
        return r.lo <= 0 && r.hi >= 0;
    endfunction

    function automatic logic [10:0] sum_exponent(input span_t a, input span_t b);
        logic [10:0] e;
        e = (a.ex > b.ex) ? a.ex : b.ex;
        if (e <= EXP_FIN_MAX) e++;
        if (a.ex >= EXP_INF && b.ex >= EXP_INF) e = EXP_NAN;
        return e;
    endfunction

    function automatic bit shl_fits(input logic [31:0] u, input int s);
        logic [31:0] t;
        t = ((u << s) << 1);
        t = (t >> s) >> 1;
        return t == u;
    endfunction

    function automatic logic [31:0] magnitude(input logic signed [31:0] x);
        return (x < 0) ? (32'd0 - x) : x;
    endfunction

    function automatic span_t or_span(input span_t a, input span_t b);
        logic signed [31:0] lo, hi;
        int ca, cb;
        lo = I32_MIN; hi = I32_MAX;
        if (a.lo == a.hi) begin
            if (a.lo == 0) return b;
            if (a.lo == -1) return a;
        end
        if (b.lo == b.hi) begin
            if (b.lo == 0) return a;
            if (b.lo == -1) return b;
        end
        if (a.lo >= 0 && b.lo >= 0) begin
            ca = lead_zeros(a.hi);
            cb = lead_zeros(b.hi);
            lo = bigger(a.lo, b.lo);
            hi = low_ones(ca < cb ? ca : cb);
        end else begin
            if (a.hi < 0) begin
                lo = bigger(lo, ~low_ones(lead_zeros(~a.lo)));
                hi = -1;
            end
            if (b.hi < 0) begin
                lo = bigger(lo, ~low_ones(lead_zeros(~b.lo)));
                hi = -1;
            end
        end
        return int_span(lo, hi);
    endfunction

    function automatic span_t xor_span(input span_t a, input span_t b);
        logic signed [31:0] al, ah, bl, bh, t, lo, hi;
        bit inv;
        al = a.lo; ah = a.hi; bl = b.lo; bh = b.hi;
        lo = I32_MIN; hi = I32_MAX; inv = 0;
        if (ah < 0) begin t = ~al; al = ~ah; ah = t; inv = !inv; end
        if (bh < 0) begin t = ~bl; bl = ~bh; bh = t; inv = !inv; end
        if (al == 0 && ah == 0) begin lo = bl; hi = bh; end
        else if (bl == 0 && bh == 0) begin lo = al; hi = ah; end
        else if (al >= 0 && bl >= 0) begin
            lo = 0;
            hi = smaller(bh | low_ones(lead_zeros(ah)), ah | low_ones(lead_zeros(bh)));
        end
        if (inv) begin t = ~lo; lo = ~hi; hi = t; end
        return int_span(lo, hi);
    endfunction

    function automatic span_t mul_span(input span_t a, input span_t b);
        bit sa, sb, nz, fr;
        logic [10:0] e;
        longint p[4];
        longint lo, hi;
        sa = !a.hl || a.lo < 0 || a.nz;
        sb = !b.hl || b.lo < 0 || b.nz;
        nz = (sa && b.hi >= 0) || (sb && a.hi >= 0);
        fr = a.fr || b.fr;
        if (a.ex < EXP_INF && b.ex < EXP_INF) begin
            e = a.ex + b.ex + 11'd1;
            if (e > EXP_FIN_MAX) e = EXP_INF;
        end else if (a.ex != EXP_NAN && b.ex != EXP_NAN &&
                     !(has_zero(a) && b.ex >= EXP_INF) && !(has_zero(b) && a.ex >= EXP_INF))
            e = EXP_INF;
        else
            e = EXP_NAN;
        if (!(a.hl && a.hu) || !(b.hl && b.hu))
            return clamp_span(-64'sd2147483649, 64'sd2147483648, fr, nz, e);
        p[0] = longint'(a.lo) * longint'(b.lo);
        p[1] = longint'(a.lo) * longint'(b.hi);
        p[2] = longint'(a.hi) * longint'(b.lo);
        p[3] = longint'(a.hi) * longint'(b.hi);
        lo = p[0]; hi = p[0];
        for (int i = 1; i < 4; i++) begin
            if (p[i] < lo) lo = p[i];
            if (p[i] > hi) hi = p[i];
        end
        return clamp_span(lo, hi, fr, nz, e);
    endfunction

    function automatic span_t round_span(input span_t a, input bit down);
        span_t r;
        logic [31:0] m;
        r = a;
        if (down && a.fr && a.hl) begin
            if (a.lo == I32_MIN) r.hl = 0;
            else r.lo = a.lo - 1;
        end
        if (r.hl && r.hu) begin
            m = (magnitude(r.lo) > magnitude(r.hi)) ? magnitude(r.lo) : magnitude(r.hi);
            r.ex = 11'(31 - lead_zeros(m | 32'd1));
        end else if (r.ex < EXP_FIN_MAX)
            r.ex++;
        r.fr = 0;
        r.empty = 0;
        return r;
    endfunction

    function automatic span_t predict_range(input stim_t s);
        span_t a, b, r;
        int sl, su, sc;
        logic [31:0] ua, ub;
        a = unpack_operand(s.a_lo, s.a_hi, s.a_flags, s.a_ex);
        b = unpack_operand(s.b_lo, s.b_hi, s.b_flags, s.b_ex);
        sc = s.sc;
        case (s.kind)
            OP_ADD: r = clamp_span(
                (a.hl && b.hl) ? longint'(a.lo) + longint'(b.lo) : -64'sd2147483649,
                (a.hu && b.hu) ? longint'(a.hi) + longint'(b.hi) : 64'sd2147483648,
                a.fr || b.fr, a.nz && b.nz, sum_exponent(a, b));
            OP_SUB: r = clamp_span(
                (a.hl && b.hu) ? longint'(a.lo) - longint'(b.hi) : -64'sd2147483649,
                (a.hu && b.hl) ? longint'(a.hi) - longint'(b.lo) : 64'sd2147483648,
                a.fr || b.fr, a.nz && has_zero(b), sum_exponent(a, b));
            OP_AND: begin
                if (a.lo < 0 && b.lo < 0) r = int_span(I32_MIN, bigger(a.hi, b.hi));
                else if (b.lo < 0) r = int_span(0, a.hi);
                else if (a.lo < 0) r = int_span(0, b.hi);
                else r = int_span(0, smaller(a.hi, b.hi));
            end
            OP_OR:  r = or_span(a, b);
            OP_XOR: r = xor_span(a, b);
            OP_NOT: r = int_span(~a.hi, ~a.lo);
            OP_MUL: r = mul_span(a, b);
            OP_LSH: begin
                if (shl_fits(a.lo, sc) && shl_fits(a.hi, sc))
                    r = int_span(a.lo << sc, a.hi << sc);
                else
                    r = int_span(I32_MIN, I32_MAX);
            end
            OP_RSH: r = int_span(a.lo >>> sc, a.hi >>> sc);
            OP_URSH: begin
                ua = a.lo; ub = a.hi;
                if (a.lo > 0 || a.hi < 0)
                    r = clamp_span(longint'(ua >> sc), longint'(ub >> sc), 0, 0, 11'd31);
                else
                    r = clamp_span(0, longint'(32'hffffffff >> sc), 0, 0, 11'd31);
            end
            OP_LSHR: r = int_span(I32_MIN, I32_MAX);
            OP_RSHR: begin
                if (longint'(b.hi) - longint'(b.lo) >= 31) begin sl = 0; su = 31; end
                else begin
                    sl = b.lo & 31;
                    su = b.hi & 31;
                    if (sl > su) begin sl = 0; su = 31; end
                end
                r = int_span((a.lo < 0) ? (a.lo >>> sl) : (a.lo >>> su),
                             (a.hi >= 0) ? (a.hi >>> sl) : (a.hi >>> su));
            end
            OP_URSHR: begin
                ub = a.hi;
                r = clamp_span(0, (a.lo > 0) ? longint'(ub) : 64'sd4294967295, 0, 0, 11'd31);
            end
            OP_ABS: begin
                r.lo = bigger(bigger(0, a.lo), (a.hi == I32_MIN) ? I32_MAX : -a.hi);
                r.hi = bigger(bigger(0, a.hi), (a.lo == I32_MIN) ? I32_MAX : -a.lo);
                r.hl = 1; r.hu = a.hl && a.hu && a.lo != I32_MIN;
                r.fr = a.fr; r.nz = 0; r.ex = a.ex; r.empty = 0;
            end
            OP_MIN: begin
                r.lo = smaller(a.lo, b.lo); r.hi = smaller(a.hi, b.hi);
                r.hl = a.hl && b.hl; r.hu = a.hu || b.hu;
                r.fr = a.fr || b.fr; r.nz = a.nz || b.nz;
                r.ex = (a.ex > b.ex) ? a.ex : b.ex; r.empty = 0;
            end
            OP_MAX: begin
                r.lo = bigger(a.lo, b.lo); r.hi = bigger(a.hi, b.hi);
                r.hl = a.hl || b.hl; r.hu = a.hu && b.hu;
                r.fr = a.fr || b.fr; r.nz = a.nz || b.nz;
                r.ex = (a.ex > b.ex) ? a.ex : b.ex; r.empty = 0;
            end
            OP_FLOOR: r = round_span(a, 1);
            OP_CEIL:  r = round_span(a, 0);
            OP_SIGN: begin
                if (a.ex == EXP_NAN) r = unknown_span(0);
                else r = clamp_span(longint'(bigger(smaller(a.lo, 1), -1)),
                                    longint'(bigger(smaller(a.hi, 1), -1)), 0, a.nz, 11'd0);
            end
            OP_ISECT: begin
                r.lo = bigger(a.lo, b.lo);
                r.hi = smaller(a.hi, b.hi);
                if (r.hi < r.lo) r = unknown_span(a.ex != EXP_NAN || b.ex != EXP_NAN);
                else begin
                    r.hl = a.hl || b.hl; r.hu = a.hu || b.hu;
                    r.nz = a.nz && b.nz; r.fr = a.fr && b.fr;
                    r.ex = (a.ex < b.ex) ? a.ex : b.ex; r.empty = 0;
                    if (r.hl && r.hu && r.ex == EXP_NAN) r = unknown_span(0);
                end
            end
            OP_UNION: begin
                r.lo = smaller(a.lo, b.lo); r.hi = bigger(a.hi, b.hi);
                r.hl = a.hl && b.hl; r.hu = a.hu && b.hu;
                r.fr = a.fr || b.fr; r.nz = a.nz || b.nz;
                r.ex = (a.ex > b.ex) ? a.ex : b.ex; r.empty = 0;
            end
            default: r = unknown_span(0);
        endcase
        return r;
    endfunction

    // ---------------- stimulus ----------------

    function automatic stim_t mk(input logic [4:0] k,
                                 input logic signed [31:0] al, input logic signed [31:0] ah,
                                 input logic [3:0] af, input logic [10:0] ae,
                                 input logic signed [31:0] bl, input logic signed [31:0] bh,
                                 input logic [3:0] bf, input logic [10:0] be,
                                 input logic [4:0] sc);
        stim_t s;
        s.kind = k; s.a_lo = al; s.a_hi = ah; s.a_flags = af; s.a_ex = ae;
        s.b_lo = bl; s.b_hi = bh; s.b_flags = bf; s.b_ex = be; s.sc = sc;
        return s;
    endfunction

    function automatic logic signed [31:0] pick_bound();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 80) - 40;
            1: return I32_MAX - $urandom_range(0, 3);
            2: return I32_MIN + $urandom_range(0, 3);
            3: return 32'sd1 <<< $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [10:0] pick_exponent();
        case ($urandom_range(0, 5))
            0: return 11'd31;
            1: return EXP_INF;
            2: return EXP_NAN;
            3: return $urandom_range(1000, 1023);
            default: return $urandom_range(0, 1025);
        endcase
    endfunction

    function automatic stim_t random_stim();
        stim_t s;
        logic signed [31:0] t;
        s.kind = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 31) : $urandom_range(0, 20);
        s.a_lo = pick_bound(); s.a_hi = pick_bound();
        s.b_lo = pick_bound(); s.b_hi = pick_bound();
        // Most ranges are ordered; a few stay inverted on purpose.
        if ($urandom_range(0, 9) != 0 && s.a_lo > s.a_hi) begin
            t = s.a_lo; s.a_lo = s.a_hi; s.a_hi = t;
        end
        if ($urandom_range(0, 9) != 0 && s.b_lo > s.b_hi) begin
            t = s.b_lo; s.b_lo = s.b_hi; s.b_hi = t;
        end
        s.a_flags = $urandom_range(0, 15); s.b_flags = $urandom_range(0, 15);
        s.a_ex = pick_exponent(); s.b_ex = pick_exponent();
        s.sc = $urandom_range(0, 31);
        return s;
    endfunction

    task automatic send_item(input stim_t s, input bit has_exp, input span_t exp);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid <= 1'b1;
        kind <= s.kind;
        left_lower <= s.a_lo; left_upper <= s.a_hi;
        left_flags <= s.a_flags; left_exponent <= s.a_ex;
        right_lower <= s.b_lo; right_upper <= s.b_hi;
        right_flags <= s.b_flags; right_exponent <= s.b_ex;
        shift_count <= s.sc;
        do @(posedge clk); while (stall);
        pending_spans.push_back(has_exp ? exp : predict_range(s));
    endtask

    // ---------------- result side ----------------

    initial
    begin
        int hold;
        bit long_done;
        span_t e;
        long_done = 0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(0, 4);
            if ($urandom_range(0, 2) == 0) hold = 0;
            if (!long_done && results_seen == 300)
            begin
                hold = LONG_HOLD;
                long_done = 1;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (pending_spans.size() == 0)
            begin
                $error("result item with no expectation pending");
                failures++;
            end
            else
            begin
                e = pending_spans.pop_front();
                if (out_lower !== e.lo)
                begin
                    $error("out_lower: expected %0d, actual %0d", e.lo, out_lower);
                    failures++;
                end
                if (out_upper !== e.hi)
                begin
                    $error("out_upper: expected %0d, actual %0d", e.hi, out_upper);
                    failures++;
                end
                if (out_flags !== {e.nz, e.fr, e.hu, e.hl})
                begin
                    $error("out_flags: expected %b, actual %b", {e.nz, e.fr, e.hu, e.hl},
                           out_flags);
                    failures++;
                end
                if (out_exponent !== e.ex)
                begin
                    $error("out_exponent: expected %0d, actual %0d", e.ex, out_exponent);
                    failures++;
                end
                if (out_empty !== e.empty)
                begin
                    $error("out_empty: expected %0d, actual %0d", e.empty, out_empty);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (valid && !stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------- main sequence ----------------

    initial
    begin
        plan_row_t row;
        span_t none;
        none = '{0, 0, 0, 0, 0, 0, 0, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rows with a typed-in answer first.
        row.has_exp = 1;
        row.s = mk(5'd25, 1, 2, 4'hf, 11'd5, 3, 4, 4'h0, 11'd7, 0);
        row.exp = '{I32_MIN, I32_MAX, 0, 0, 1, 1, EXP_NAN, 0};
        plan.push_back(row);
        row.s = mk(OP_SIGN, -5, 5, 4'h3, EXP_NAN, 0, 0, 4'h3, 11'd31, 0);
        row.exp = '{I32_MIN, I32_MAX, 0, 0, 1, 1, EXP_NAN, 0};
        plan.push_back(row);
        row.s = mk(OP_ISECT, 10, 20, 4'h3, 11'd31, 30, 40, 4'h3, 11'd31, 0);
        row.exp = '{I32_MIN, I32_MAX, 0, 0, 1, 1, EXP_NAN, 1};
        plan.push_back(row);
        row.s = mk(OP_NOT, I32_MIN, I32_MAX, 4'h0, 11'd0, 0, 0, 4'h0, 11'd0, 0);
        row.exp = '{I32_MIN, I32_MAX, 1, 1, 0, 0, 11'd31, 0};
        plan.push_back(row);
        // Sum above int32 clamps both bounds to the top; only the upper becomes invalid.
        row.s = mk(OP_ADD, I32_MAX, I32_MAX, 4'h3, 11'd31, 1, 1, 4'h3, 11'd31, 0);
        row.exp = '{I32_MAX, I32_MAX, 1, 0, 0, 0, 11'd32, 0};
        plan.push_back(row);

        row.has_exp = 0;
        row.exp = none;
        plan.push_back('{mk(OP_SUB, I32_MIN, I32_MIN, 4'h3, 11'd31, 1, 1, 4'h3, 11'd31, 0), 0, none});
        plan.push_back('{mk(OP_AND, -8, -1, 4'h3, 11'd3, -4, 7, 4'h3, 11'd3, 0), 0, none});
        plan.push_back('{mk(OP_OR, 3, 9, 4'h3, 11'd4, 0, 0, 4'hc, 11'd0, 0), 0, none});
        plan.push_back('{mk(OP_OR, 0, 0, 4'h3, 11'd0, 0, 0, 4'h3, 11'd0, 0), 0, none});
        plan.push_back('{mk(OP_XOR, -9, -2, 4'h3, 11'd4, 5, 12, 4'h3, 11'd4, 0), 0, none});
        plan.push_back('{mk(OP_MUL, I32_MIN, I32_MAX, 4'hf, 11'd1023, I32_MIN, I32_MAX,
                            4'h3, 11'd1023, 0), 0, none});
        plan.push_back('{mk(OP_MUL, -3, 4, 4'h3, EXP_INF, 2, 5, 4'h3, 11'd3, 0), 0, none});
        plan.push_back('{mk(OP_LSH, 1, 3, 4'h3, 11'd2, 0, 0, 4'h0, 11'd0, 31), 0, none});
        plan.push_back('{mk(OP_RSH, I32_MIN, -1, 4'h3, 11'd31, 0, 0, 4'h0, 11'd0, 31), 0, none});
        plan.push_back('{mk(OP_URSH, -1, 5, 4'h3, 11'd31, 0, 0, 4'h0, 11'd0, 0), 0, none});
        plan.push_back('{mk(OP_LSHR, 1, 2, 4'h3, 11'd1, 0, 31, 4'h3, 11'd5, 0), 0, none});
        plan.push_back('{mk(OP_RSHR, -100, 100, 4'h3, 11'd7, 30, 33, 4'h3, 11'd6, 0), 0, none});
        plan.push_back('{mk(OP_URSHR, 4, 900, 4'h3, 11'd10, 2, 3, 4'h3, 11'd2, 0), 0, none});
        plan.push_back('{mk(OP_ABS, I32_MIN, 7, 4'h7, 11'd31, 0, 0, 4'h0, 11'd0, 0), 0, none});
        plan.push_back('{mk(OP_MIN, -5, 9, 4'h5, 11'd4, 2, 3, 4'ha, 11'd2, 0), 0, none});
        plan.push_back('{mk(OP_MAX, -5, 9, 4'h5, 11'd4, 2, 3, 4'ha, 11'd2, 0), 0, none});
        plan.push_back('{mk(OP_FLOOR, I32_MIN, 40, 4'h7, 11'd2047, 0, 0, 4'h0, 11'd0, 0), 0, none});
        plan.push_back('{mk(OP_CEIL, -3, I32_MAX, 4'h6, 11'd1022, 0, 0, 4'h0, 11'd0, 0), 0, none});
        plan.push_back('{mk(OP_ISECT, 0, 10, 4'h3, EXP_NAN, 5, 20, 4'h0, EXP_NAN, 0), 0, none});
        plan.push_back('{mk(OP_UNION, -2, 2, 4'h1, 11'd2, 8, 9, 4'h2, 11'd4, 0), 0, none});

        foreach (plan[i])
            send_item(plan[i].s, plan[i].has_exp, plan[i].exp);
        repeat (RANDOM_ITEMS)
            send_item(random_stim(), 0, none);
        valid <= 1'b0;

        while (pending_spans.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== int32_range_interval_alu_top.f =====
src/ria_pkg.sv
src/ria_decode.sv
src/ria_mul.sv
src/ria_finish.sv
src/int32_range_interval_alu_top.sv
src/ria_checker.sv
dv/tb.sv
